@@ design/mfh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfh_pkg
// Shared types, constants and helpers for the masked-field histogram.
// ----------------------------------------------------------------------------
package mfh_pkg;

	localparam int NUM_BINS   = 256;
	localparam int IDX_W      = $clog2(NUM_BINS);
	localparam int WORD_W     = 32;
	localparam int BIN_OUT_W  = 8;
	localparam int SHIFT_W    = 5;
	localparam logic [WORD_W-1:0] MASK_RESET = 32'h0000_00FF;

	// controller to datapath
	typedef struct packed {
		logic load;    // input word taken, form the bin index
		logic commit;  // update bin, fill output register
	} mfh_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_UPDATE = 3'b100
	} mfh_state_t;

	// trailing zero count, held at 31 for an all-zero mask
	function automatic logic [SHIFT_W-1:0] trail_zeros(input logic [WORD_W-1:0] m);
		logic [SHIFT_W-1:0] n;
		n = SHIFT_W'(WORD_W - 1);
		for (int i = WORD_W - 2; i >= 0; i--) begin
			if (m[i]) begin
				n = SHIFT_W'(i);
			end
		end
		return n;
	endfunction

endpackage

@@ design/mfh_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/mfh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfh_ctrl
// Sequencer: accept, counter read, counter update, output handshake.
// ----------------------------------------------------------------------------
module mfh_ctrl
	import mfh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output mfh_cmd_t cmd
);

	mfh_state_t state_q;
	logic       out_vld_q;
	logic       slot_free;

	assign slot_free  = !out_vld_q || m_tready;
	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.load   = s_tvalid && (state_q == ST_IDLE);
	assign cmd.commit = (state_q == ST_UPDATE) && slot_free;
	assign m_tvalid   = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.commit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

endmodule

@@ design/mfh_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfh_dp
// Datapath: mask register, bin index, counter RAM, increment, output word.
// ----------------------------------------------------------------------------
module mfh_dp
	import mfh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [WORD_W-1:0]    cfg_wdata,
	input  mfh_cmd_t             cmd,
	input  logic [WORD_W-1:0]    sample,
	input  logic                 last_sample,
	output logic [BIN_OUT_W-1:0] bin_index,
	output logic [WORD_W-1:0]    new_count,
	output logic                 counted,
	output logic                 batch_end
);

	logic [WORD_W-1:0]    mask_q;
	logic [SHIFT_W-1:0]   shift_q;
	logic [WORD_W-1:0]    idx_full;
	logic                 in_range;

	logic [IDX_W-1:0]     addr_s1;
	logic [BIN_OUT_W-1:0] bin_s1;
	logic                 hit_s1;
	logic                 last_s1;

	logic [NUM_BINS-1:0]  vld_q;
	logic [WORD_W-1:0]    rdata;
	logic [WORD_W-1:0]    cur_cnt;
	logic [WORD_W-1:0]    inc_cnt;
	logic                 ram_we;

	// mask and its shift, shift worked out once per write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= MASK_RESET;
			shift_q <= trail_zeros(MASK_RESET);
		end else if (cfg_we) begin
			mask_q  <= cfg_wdata;
			shift_q <= trail_zeros(cfg_wdata);
		end
	end

	assign idx_full = (sample & mask_q) >> shift_q;
	assign in_range = (idx_full < WORD_W'(NUM_BINS));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_s1 <= idx_full[IDX_W-1:0];
			bin_s1  <= idx_full[BIN_OUT_W-1:0];
			hit_s1  <= (mask_q != '0) && in_range;
			last_s1 <= last_sample;
		end
	end

	mfh_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_BINS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(inc_cnt),
		.raddr(addr_s1),
		.rdata(rdata)
	);

	// never-written bins read as zero
	assign cur_cnt = vld_q[addr_s1] ? rdata : '0;
	assign inc_cnt = cur_cnt + WORD_W'(1);
	assign ram_we  = cmd.commit && hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			bin_index <= bin_s1;
			new_count <= hit_s1 ? inc_cnt : '0;
			counted   <= hit_s1;
			batch_end <= last_s1;
		end
	end

endmodule

@@ design/masked_field_histogram_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_field_histogram_unit
// Histogram bin counter over a masked field of each 32-bit input word.
// ----------------------------------------------------------------------------
// Each input word is ANDed with bin_mask and shifted right by the mask's
// trailing zero count to give a bin index. If the mask is nonzero and the
// index is below the bin count (256), that bin's 32-bit counter is bumped
// (wrapping at 2^32) and the new value is returned with counted = 1;
// otherwise no counter changes, new_count is 0 and counted is 0. The low
// 8 bits of the index are always returned, and tlast is echoed through.
// One output word per input word, in order.
// Per word: index formed and registered on accept (ST_IDLE), registered read
// of the counter RAM (ST_LOOKUP), increment and write-back (ST_UPDATE). That
// read-modify-write loop through the counter RAM sets the rate: a new word is
// accepted only after the last is written back. The output register lets the
// next word be accepted while a result still waits on m_tready. Counters read
// as zero after reset through per-bin valid flops; there is no clearing pass,
// so the block is ready right after reset. bin_mask (reset 0xFF) is written
// via cfg_we/cfg_wdata; the user must write it only while idle (unenforced).
// ----------------------------------------------------------------------------
module masked_field_histogram_unit
	import mfh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,   // bin_mask
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // [31:0] sample
	input  logic        s_tlast,     // last_sample
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,     // [7:0] bin_index, [39:8] new_count
	output logic        m_tuser,     // counted
	output logic        m_tlast      // batch_end
);

	mfh_cmd_t             cmd;
	logic [BIN_OUT_W-1:0] bin_index;
	logic [WORD_W-1:0]    new_count;

	// sequencer
	mfh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd)
	);

	// index, counters, output register
	mfh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.sample     (s_tdata),
		.last_sample(s_tlast),
		.bin_index  (bin_index),
		.new_count  (new_count),
		.counted    (m_tuser),
		.batch_end  (m_tlast)
	);

	assign m_tdata = {new_count, bin_index};

endmodule
